/* hdl/udp_checksum_verify_engine_macros.svh */
// Assertion helpers shared by the engine's modules.
`ifndef UDP_CHECKSUM_VERIFY_ENGINE_MACROS_SVH
`define UDP_CHECKSUM_VERIFY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define UCV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define UCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ucv_pkg.sv */
package ucv_pkg;

  typedef struct packed {
    logic ip_version;
    logic direction;
  } ucv_cfg_t;

  // One classified word on its way from front to back.
  typedef struct packed {
    logic [15:0] val;        // contribution to the sum after masking
    logic [15:0] extra;      // folded protocol plus length, used on last only
    logic        last;
    logic        length_ok;
    logic        rc_pass;    // IPv4 with received checksum of zero
  } ucv_entry_t;

  localparam logic        OpAddr       = 1'b0;
  localparam logic        OpData       = 1'b1;
  localparam logic        DirTx        = 1'b0;
  localparam logic        DirRx        = 1'b1;
  localparam logic        IpV4         = 1'b0;
  localparam logic        IpV6         = 1'b1;
  localparam logic        RegIpVersion = 1'b0;
  localparam logic        RegDirection = 1'b1;

  localparam logic [15:0] UdpProtocol      = 16'd17;
  localparam logic [16:0] MinUdpLength     = 17'd8;
  localparam logic [16:0] MaxDatagramBytes = 17'd65535;
  localparam logic [16:0] ByteCountSat     = MaxDatagramBytes + 17'd1;
  localparam logic [16:0] OffsetLength     = 17'd4;
  localparam logic [16:0] OffsetChecksum   = 17'd6;
  localparam logic [1:0]  BytesOne         = 2'd1;

  localparam int QueueDepth = 2;

  // Ones'-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

/* hdl/ucv_in_if.sv */
interface ucv_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] word;
  logic [1:0]  bytes_valid;
  logic        last;

  modport source (output valid, opcode, word, bytes_valid, last, input ready);
  modport sink   (input valid, opcode, word, bytes_valid, last, output ready);
endinterface

/* hdl/ucv_out_if.sv */
interface ucv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic [15:0] tx_checksum;
  logic        length_ok;
  logic        checksum_ok;
  logic        accept;

  modport source (output valid, checksum, tx_checksum, length_ok, checksum_ok, accept,
                  input ready);
  modport sink   (input valid, checksum, tx_checksum, length_ok, checksum_ok, accept,
                  output ready);
endinterface

/* hdl/ucv_fifo.sv */
`include "udp_checksum_verify_engine_macros.svh"

module ucv_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ucv_pkg::ucv_entry_t data_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ucv_pkg::ucv_entry_t data_o
);
  import ucv_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  ucv_entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign ready_o = (count_q != Full);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `UCV_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push_i, count_q != Full, "queue overflow")
  `UCV_ASSERT_SAME(a_no_underflow, clk_i, rst_ni, pop_i, count_q != '0, "queue underflow")
  `UCV_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + CntW'(1), "count did not advance")
endmodule

/* hdl/ucv_front.sv */
module ucv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucv_pkg::ucv_cfg_t   cfg_i,
  ucv_in_if.sink              in_i,
  input  logic                q_ready_i,
  output logic                push_o,
  output ucv_pkg::ucv_entry_t entry_o
);
  import ucv_pkg::*;

  logic [16:0] byte_count_q, byte_count_d;
  logic [15:0] header_length_q, header_length_d;
  logic [15:0] received_checksum_q, received_checksum_d;

  logic [16:0] pos;
  logic [16:0] count_sum;
  logic [16:0] len;
  logic [16:0] ext_sum;
  logic [15:0] val;
  logic [15:0] kept;
  logic        one_byte;
  logic        lok_rx;
  logic        lok_tx;

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

  always_comb begin
    pos                 = byte_count_q;
    one_byte            = (in_i.bytes_valid == BytesOne);
    val                 = one_byte ? {in_i.word[15:8], 8'h00} : in_i.word;
    kept                = in_i.word;
    byte_count_d        = byte_count_q;
    header_length_d     = header_length_q;
    received_checksum_d = received_checksum_q;
    count_sum           = pos + (one_byte ? 17'd1 : 17'd2);

    if (in_i.opcode == OpData) begin
      kept = val;
      if (pos == OffsetLength) begin
        header_length_d = val;
      end else if (pos == OffsetChecksum) begin
        received_checksum_d = val;
      end
      // Drop receive bytes that lie past the header length.
      if (cfg_i.direction == DirRx && pos >= OffsetChecksum) begin
        kept[15:8] = (pos < {1'b0, header_length_q}) ? val[15:8] : 8'h00;
        kept[7:0]  = ((pos + 17'd1) < {1'b0, header_length_q}) ? val[7:0] : 8'h00;
      end
      byte_count_d = (count_sum > ByteCountSat) ? ByteCountSat : count_sum;
    end

    len     = (cfg_i.direction == DirRx) ? {1'b0, header_length_d} : byte_count_d;
    ext_sum = {1'b0, UdpProtocol} + {1'b0, len[15:0]} + {16'b0, len[16]};

    lok_rx = ({1'b0, header_length_d} >= MinUdpLength) &&
             ({1'b0, header_length_d} <= byte_count_d) &&
             ({1'b0, header_length_d} <= MaxDatagramBytes) &&
             (byte_count_d <= MaxDatagramBytes);
    lok_tx = (byte_count_d >= MinUdpLength) && (byte_count_d <= MaxDatagramBytes);

    entry_o.val       = kept;
    entry_o.extra     = ext_sum[15:0] + {15'b0, ext_sum[16]};
    entry_o.last      = in_i.last;
    entry_o.length_ok = (cfg_i.direction == DirRx) ? lok_rx : lok_tx;
    entry_o.rc_pass   = (cfg_i.ip_version == IpV4) && (received_checksum_d == 16'h0000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q        <= '0;
      header_length_q     <= '0;
      received_checksum_q <= '0;
    end else if (push_o) begin
      if (in_i.last) begin
        byte_count_q        <= '0;
        header_length_q     <= '0;
        received_checksum_q <= '0;
      end else begin
        byte_count_q        <= byte_count_d;
        header_length_q     <= header_length_d;
        received_checksum_q <= received_checksum_d;
      end
    end
  end
endmodule

/* hdl/ucv_back.sv */
`include "udp_checksum_verify_engine_macros.svh"

module ucv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ucv_pkg::ucv_entry_t q_data_i,
  output logic                pop_o,
  ucv_out_if.source           out_o
);
  import ucv_pkg::*;

  logic [15:0] acc_q, acc_d;
  logic        valid_q, valid_d;
  logic [15:0] csum_q;
  logic        lok_q;
  logic        cok_q;

  logic [15:0] nsum;
  logic [15:0] fsum;
  logic [15:0] csum;

  // A last word waits only while the result register is still held.
  assign pop_o = q_valid_i && (!q_data_i.last || !valid_q || out_o.ready);

  always_comb begin
    nsum    = oc_add(acc_q, q_data_i.val);
    fsum    = oc_add(nsum, q_data_i.extra);
    csum    = ~fsum;
    acc_d   = acc_q;
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (pop_o) begin
      acc_d = q_data_i.last ? 16'h0000 : nsum;
      if (q_data_i.last) begin
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.last) begin
      csum_q <= csum;
      lok_q  <= q_data_i.length_ok;
      cok_q  <= (csum == 16'h0000) || q_data_i.rc_pass;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.checksum    = csum_q;
  assign out_o.tx_checksum = (csum_q == 16'h0000) ? 16'hFFFF : csum_q;
  assign out_o.length_ok   = lok_q;
  assign out_o.checksum_ok = cok_q;
  assign out_o.accept      = lok_q && cok_q;

  `UCV_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, pop_o && q_data_i.last, valid_q && acc_q == 16'h0000, "last word left no result")
endmodule

/* hdl/udp_checksum_verify_engine.sv */
// A result is registered: its last word is written into the queue and, once popped, sets
// the result register; a result still held at the output can keep that word waiting.
// Throughput: one word per cycle; the two-entry queue and the result register
// stall input only when a last word meets a result still held at the output.
// Reset (rst_ni low, asynchronous): config registers, packet state, queue and
// result valid clear at once; no clearing pass is needed.
module udp_checksum_verify_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ucv_in_if.sink      in_i,
  ucv_out_if.source   out_o
);
  import ucv_pkg::*;

  ucv_cfg_t   cfg_q;
  ucv_entry_t push_entry;
  ucv_entry_t pop_entry;
  logic       push;
  logic       pop;
  logic       q_ready;
  logic       q_valid;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegDirection) ? {31'b0, cfg_q.direction}
                                             : {31'b0, cfg_q.ip_version};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      if (paddr[2] == RegIpVersion) begin
        cfg_q.ip_version <= pwdata[0];
      end else begin
        cfg_q.direction <= pwdata[0];
      end
    end
  end

  ucv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  ucv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_entry)
  );

  ucv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (pop_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );
endmodule

/* verif/ucv_result_checker.sv */
module ucv_result_checker
  import ucv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  ucv_in_if           in_mon_i,
  ucv_out_if          out_mon_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] tx_checksum;
    logic        length_ok;
    logic        checksum_ok;
    logic        accept;
  } udp_verdict_t;

  logic         use_ipv6 = IpV4;
  logic         rx_mode = DirTx;
  logic [15:0]  acc = '0;
  logic [16:0]  nbytes = '0;
  logic [15:0]  hdr_len = '0;
  logic [15:0]  rx_csum = '0;
  udp_verdict_t verdicts_due[$];
  int           fails = 0;

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  task automatic clear_datagram();
    acc = '0;
    nbytes = '0;
    hdr_len = '0;
    rx_csum = '0;
  endtask

  task automatic absorb_word(input logic op, input logic [15:0] w, input logic [1:0] bv,
                             input logic lst);
    logic [15:0]  v;
    logic [15:0]  kept;
    logic [16:0]  pos;
    logic [17:0]  nxt;
    logic [16:0]  len;
    logic [15:0]  s;
    udp_verdict_t r;
    if (op == OpData) begin
      pos = nbytes;
      v = (bv == BytesOne) ? {w[15:8], 8'h00} : w;
      if (pos == OffsetLength) hdr_len = v;
      else if (pos == OffsetChecksum) rx_csum = v;
      // in receive mode, from the checksum word on, keep only bytes inside the header length
      if (rx_mode == DirRx && pos >= OffsetChecksum) begin
        kept = '0;
        if (pos < {1'b0, hdr_len}) kept[15:8] = v[15:8];
        if (pos + 17'd1 < {1'b0, hdr_len}) kept[7:0] = v[7:0];
        v = kept;
      end
      acc = fold_add(acc, v);
      nxt = {1'b0, pos} + ((bv == BytesOne) ? 18'd1 : 18'd2);
      nbytes = (nxt > {1'b0, ByteCountSat}) ? ByteCountSat : nxt[16:0];
    end else begin
      acc = fold_add(acc, w);
    end
    if (lst) begin
      len = (rx_mode == DirRx) ? {1'b0, hdr_len} : nbytes;
      s = fold_add(acc, UdpProtocol);
      s = fold_add(s, len[15:0]);
      s = fold_add(s, {15'd0, len[16]});
      r.checksum = ~s;
      r.tx_checksum = (r.checksum == 16'h0000) ? 16'hFFFF : r.checksum;
      if (rx_mode == DirRx)
        r.length_ok = ({1'b0, hdr_len} >= MinUdpLength) && ({1'b0, hdr_len} <= nbytes) &&
                      (nbytes <= MaxDatagramBytes);
      else
        r.length_ok = (nbytes >= MinUdpLength) && (nbytes <= MaxDatagramBytes);
      r.checksum_ok = (r.checksum == 16'h0000) || (use_ipv6 == IpV4 && rx_csum == 16'h0000);
      r.accept = r.length_ok && r.checksum_ok;
      verdicts_due.push_back(r);
      clear_datagram();
    end
  endtask

  task automatic compare_verdict(input udp_verdict_t want);
    if (out_mon_i.checksum !== want.checksum) begin
      $error("checksum: expected %h, got %h", want.checksum, out_mon_i.checksum);
      fails++;
    end
    if (out_mon_i.tx_checksum !== want.tx_checksum) begin
      $error("tx_checksum: expected %h, got %h", want.tx_checksum, out_mon_i.tx_checksum);
      fails++;
    end
    if (out_mon_i.length_ok !== want.length_ok) begin
      $error("length_ok: expected %b, got %b", want.length_ok, out_mon_i.length_ok);
      fails++;
    end
    if (out_mon_i.checksum_ok !== want.checksum_ok) begin
      $error("checksum_ok: expected %b, got %b", want.checksum_ok, out_mon_i.checksum_ok);
      fails++;
    end
    if (out_mon_i.accept !== want.accept) begin
      $error("accept: expected %b, got %b", want.accept, out_mon_i.accept);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_ipv6 = IpV4;
      rx_mode = DirTx;
      clear_datagram();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {RegIpVersion, 2'b00}: use_ipv6 = pwdata[0];
          {RegDirection, 2'b00}: rx_mode = pwdata[0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready)
        absorb_word(in_mon_i.opcode, in_mon_i.word, in_mon_i.bytes_valid, in_mon_i.last);
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result with nothing outstanding: checksum %h", out_mon_i.checksum);
          fails++;
        end else begin
          compare_verdict(verdicts_due.pop_front());
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= verdicts_due.size();
  end

endmodule

/* verif/tb_udp_checksum_verify_engine.sv */
module tb_udp_checksum_verify_engine;
  import ucv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200_000;

  typedef enum int {CsumGood, CsumZero, CsumRandom} csum_fill_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          words_sent = 0;
  int          cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  ucv_in_if  in_ch ();
  ucv_out_if out_ch ();

  udp_checksum_verify_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  ucv_result_checker csum_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] ones_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[16]) s = s + 17'd1;
    return s[15:0];
  endfunction

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic op, input logic [15:0] w, input logic [1:0] bv,
                           input logic lst);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.word <= w;
    in_ch.bytes_valid <= bv;
    in_ch.last <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Pseudo-header words, then the UDP header, payload and any trailing bytes.
  task automatic send_datagram(input int addr_words, input int pay_len, input int trail,
                               input int len_field, input csum_fill_e fill);
    logic [7:0]  oct[$];
    logic [15:0] addr[$];
    logic [15:0] acc;
    logic [15:0] csum;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [1:0]  bv;
    int          total;
    int          i;
    if ($urandom_range(0, 3) == 0) in_calm = ~in_calm;
    total = 8 + pay_len + trail;
    repeat (addr_words) addr.push_back(16'($urandom));
    repeat (total) oct.push_back(8'($urandom));
    oct[4] = 8'(len_field >> 8);
    oct[5] = 8'(len_field);
    oct[6] = 8'h00;
    oct[7] = 8'h00;
    case (fill)
      CsumGood: begin
        acc = '0;
        foreach (addr[k]) acc = ones_sum(acc, addr[k]);
        for (i = 0; i < len_field; i += 2) begin
          hi = (i < total) ? oct[i] : 8'h00;
          lo = (i + 1 < len_field && i + 1 < total) ? oct[i + 1] : 8'h00;
          acc = ones_sum(acc, {hi, lo});
        end
        acc = ones_sum(acc, UdpProtocol);
        acc = ones_sum(acc, 16'(len_field));
        csum = ~acc;
        if (csum == 16'h0000) csum = 16'hFFFF;
      end
      CsumZero: csum = 16'h0000;
      default:  csum = 16'($urandom);
    endcase
    oct[6] = csum[15:8];
    oct[7] = csum[7:0];
    foreach (addr[k]) send_word(OpAddr, addr[k], 2'd2, 1'b0);
    for (i = 0; i < total; i += 2) begin
      if (i + 1 < total) begin
        bv = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1) * 3) : 2'd2;
        send_word(OpData, {oct[i], oct[i + 1]}, bv, i + 2 >= total);
      end else begin
        send_word(OpData, {oct[i], 8'($urandom)}, BytesOne, 1'b1);
      end
    end
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = ~out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    int         phase;
    int         target;
    int         n;
    int         i;
    int         aw;
    int         pay;
    int         trail;
    int         len;
    int         pick;
    logic       cur_v6;
    logic       cur_rx;
    csum_fill_e fill;

    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OpAddr;
    in_ch.word <= '0;
    in_ch.bytes_valid <= 2'd2;
    in_ch.last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg({RegIpVersion, 2'b00}, {31'd0, IpV4});
    write_reg({RegDirection, 2'b00}, {31'd0, DirTx});
    send_word(OpAddr, 16'hFFFF, 2'd2, 1'b1);       // last on a pseudo-header word
    send_word(OpData, 16'hABCD, BytesOne, 1'b0);   // odd byte mid-stream shifts offsets
    send_word(OpData, 16'h0000, 2'd3, 1'b0);
    send_word(OpData, 16'hFFFF, 2'd0, 1'b0);
    send_word(OpData, 16'h5A5A, 2'd2, 1'b0);
    send_word(OpData, 16'h0000, 2'd2, 1'b1);
    send_datagram(4, 0, 0, 8, CsumZero);           // zero checksum passes under IPv4
    send_datagram(4, 4, 0, 12, CsumGood);
    send_datagram(4, 300, 0, 308, CsumGood);       // longer payload
    settle();
    write_reg({RegDirection, 2'b00}, {31'd0, DirRx});
    send_datagram(4, 5, 3, 13, CsumGood);          // trailing bytes beyond the length
    send_datagram(4, 3, 0, 11, CsumZero);
    send_datagram(4, 10, 0, 4, CsumRandom);        // length below the minimum
    send_datagram(4, 0, 0, 30, CsumGood);          // length beyond the data
    send_datagram(0, 40, 0, 65535, CsumGood);      // largest length field, beyond the data
    settle();
    write_reg({RegIpVersion, 2'b00}, {31'd0, IpV6});
    send_datagram(16, 6, 0, 14, CsumZero);         // zero checksum fails under IPv6
    send_datagram(16, 7, 1, 15, CsumGood);
    settle();
    write_reg({RegDirection, 2'b00}, {31'd0, DirTx});
    send_datagram(16, 9, 0, 17, CsumGood);
    send_word(OpAddr, 16'h0000, BytesOne, 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      settle();
      cur_v6 = (phase < 4) ? phase[0] : 1'($urandom);
      cur_rx = (phase < 4) ? phase[1] : 1'($urandom);
      write_reg({RegIpVersion, 2'b00}, {31'($urandom), cur_v6});
      write_reg({RegDirection, 2'b00}, {31'($urandom), cur_rx});
      target = words_sent + 100;
      while (words_sent < target) begin
        if ($urandom_range(0, 3) == 0) begin
          // raw noise, closed by a last word so the next datagram starts clean
          n = $urandom_range(1, 8);
          for (i = 1; i <= n; i++)
            send_word(1'($urandom), 16'($urandom), 2'($urandom),
                      (i == n) || ($urandom_range(0, 3) == 0));
        end else begin
          aw = cur_v6 ? 16 : 4;
          if ($urandom_range(0, 15) == 0) aw = $urandom_range(0, 16);
          pay = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
          trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
          len = 8 + pay;
          pick = $urandom_range(0, 9);
          if (pick == 0) len = $urandom_range(0, 12 + pay + trail);
          else if (pick == 1) len = $urandom_range(0, 65535);
          pick = $urandom_range(0, 9);
          fill = (pick < 6) ? CsumGood : (pick < 8) ? CsumZero : CsumRandom;
          send_datagram(aw, pay, trail, len, fill);
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
